>>> design/jdm_pkg.sv
// Package: payload types, axis mapping constants and zone codes for the joystick mixer.
`timescale 1ns / 1ps

package jdm_pkg;

    // Input transfer: one raw joystick sample pair
    typedef struct packed {
        logic [11:0] stick_x;
        logic [11:0] stick_y;
    } in_t;

    // Output transfer: four wheel duties and the zone
    typedef struct packed {
        logic [7:0] right_forward_duty;
        logic [7:0] right_reverse_duty;
        logic [7:0] left_forward_duty;
        logic [7:0] left_reverse_duty;
        logic [2:0] zone;
    } out_t;

    // Mapped axis value, -255..255
    typedef logic signed [8:0] axis_t;

    // Axis break points
    localparam logic [11:0] SAMPLE_MIN = 12'd20;
    localparam logic [11:0] X_LO_EDGE  = 12'd1900;   // X center 2100 minus dead band
    localparam logic [11:0] X_HI_EDGE  = 12'd2300;
    localparam logic [11:0] Y_LO_EDGE  = 12'd2150;   // Y center 2350 minus dead band
    localparam logic [11:0] Y_HI_EDGE  = 12'd2550;
    localparam int unsigned AXIS_FULL_SCALE = 255;

    // Divisors of the linear maps
    localparam int unsigned X_LO_DIV = 1880;   // 1900 - 20
    localparam int unsigned X_HI_DIV = 1795;   // 4095 - 2300
    localparam int unsigned Y_LO_DIV = 2130;   // 2150 - 20
    localparam int unsigned Y_HI_DIV = 1545;   // 4095 - 2550

    // Scaled reciprocals ceil(2^32 / N); exact floor for any dividend below 2^20
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 22;
    localparam int PROD_W      = 20;
    localparam logic [RECIP_W-1:0] X_LO_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(X_LO_DIV) - 64'd1) / 64'(X_LO_DIV));
    localparam logic [RECIP_W-1:0] X_HI_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(X_HI_DIV) - 64'd1) / 64'(X_HI_DIV));
    localparam logic [RECIP_W-1:0] Y_LO_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(Y_LO_DIV) - 64'd1) / 64'(Y_LO_DIV));
    localparam logic [RECIP_W-1:0] Y_HI_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(Y_HI_DIV) - 64'd1) / 64'(Y_HI_DIV));

    // Turn threshold after reset
    localparam logic [7:0] THRESHOLD_RESET = 8'd60;

    // Zone codes
    localparam logic [2:0] ZONE_STOP       = 3'd0;
    localparam logic [2:0] ZONE_FWD_RIGHT  = 3'd1;
    localparam logic [2:0] ZONE_FWD_LEFT   = 3'd2;
    localparam logic [2:0] ZONE_BACK_LEFT  = 3'd3;
    localparam logic [2:0] ZONE_BACK_RIGHT = 3'd4;
    localparam logic [2:0] ZONE_FWD        = 3'd5;
    localparam logic [2:0] ZONE_BACK       = 3'd6;

endpackage

>>> design/jdm_axis_map.sv
// Dead band and linear mapping of both raw joystick axes onto -255..255.
`timescale 1ns / 1ps

module jdm_axis_map
(
    input  jdm_pkg::in_t   sample,
    output jdm_pkg::axis_t x,
    output jdm_pkg::axis_t y
);

    localparam int DW = 12;
    localparam int PW = jdm_pkg::PROD_W;
    localparam int RW = jdm_pkg::RECIP_W;
    localparam int MW = PW + RW;

    logic          x_floor;
    logic          x_lo;
    logic          x_hi;
    logic [DW-1:0] dx;
    logic [RW-1:0] rx;
    logic [PW-1:0] px;
    logic [MW-1:0] mx;
    logic [7:0]    qx;

    logic          y_lo;
    logic          y_hi;
    logic [DW-1:0] dy;
    logic [RW-1:0] ry;
    logic [PW-1:0] py;
    logic [MW-1:0] my;
    logic [8:0]    qy;

    // X: offset and divisor select for the active side
    always_comb
    begin
        x_floor = sample.stick_x < jdm_pkg::SAMPLE_MIN;
        x_lo    = sample.stick_x < jdm_pkg::X_LO_EDGE;
        x_hi    = sample.stick_x > jdm_pkg::X_HI_EDGE;
        if (x_lo)
        begin
            dx = sample.stick_x - jdm_pkg::SAMPLE_MIN;
            rx = jdm_pkg::X_LO_RECIP;
        end
        else
        begin
            dx = sample.stick_x - jdm_pkg::X_HI_EDGE;
            rx = jdm_pkg::X_HI_RECIP;
        end
        // d * 255 as shift and subtract, then divide by reciprocal multiply
        px = {dx, 8'd0} - {8'd0, dx};
        mx = MW'(px) * MW'(rx);
        qx = mx[jdm_pkg::RECIP_SHIFT +: 8];
    end

    // X: assemble signed value
    always_comb
    begin
        if (x_floor)
            x = -9'sd255;
        else if (x_lo)
            x = $signed({1'b0, qx}) - 9'sd255;
        else if (x_hi)
            x = $signed({1'b0, qx});
        else
            x = 9'sd0;
    end

    // Y: offset and divisor select for the active side
    always_comb
    begin
        y_lo = sample.stick_y < jdm_pkg::Y_LO_EDGE;
        y_hi = sample.stick_y > jdm_pkg::Y_HI_EDGE;
        if (y_lo)
        begin
            dy = jdm_pkg::Y_LO_EDGE - sample.stick_y;
            ry = jdm_pkg::Y_LO_RECIP;
        end
        else
        begin
            dy = sample.stick_y - jdm_pkg::Y_HI_EDGE;
            ry = jdm_pkg::Y_HI_RECIP;
        end
        py = {dy, 8'd0} - {8'd0, dy};
        my = MW'(py) * MW'(ry);
        qy = my[jdm_pkg::RECIP_SHIFT +: 9];
    end

    // Y: assemble signed value, low side saturates at -255
    always_comb
    begin
        if (y_lo)
        begin
            if (qy > 9'(jdm_pkg::AXIS_FULL_SCALE))
                y = -9'sd255;
            else
                y = 9'sd0 - $signed({1'b0, qy[7:0]});
        end
        else if (y_hi)
            y = $signed({1'b0, qy[7:0]});
        else
            y = 9'sd0;
    end

endmodule

>>> design/jdm_zone_mix.sv
// Zone selection and wheel duty mixing from the mapped axis pair.
`timescale 1ns / 1ps

module jdm_zone_mix
(
    input  jdm_pkg::axis_t x,
    input  jdm_pkg::axis_t y,
    input  logic [7:0]     turn_threshold,
    output jdm_pkg::out_t  result
);

    logic [7:0]       ax;
    logic [7:0]       ay;
    logic [7:0]       hi;
    logic [7:0]       lo;
    logic signed [8:0] t_pos;
    logic signed [8:0] t_neg;
    logic             fwd;
    logic [7:0]       left;
    logic [7:0]       right;
    logic [2:0]       zone;

    // Magnitudes and their max / min
    always_comb
    begin
        ax = x[8] ? 8'(9'sd0 - x) : x[7:0];
        ay = y[8] ? 8'(9'sd0 - y) : y[7:0];
        hi = (ax > ay) ? ax : ay;
        lo = (ax < ay) ? ax : ay;
        t_pos = $signed({1'b0, turn_threshold});
        t_neg = 9'sd0 - t_pos;
    end

    // Zone decision; y in its dead band stops both wheels
    always_comb
    begin
        fwd   = 1'b1;
        left  = 8'd0;
        right = 8'd0;
        zone  = jdm_pkg::ZONE_STOP;
        if (y != 9'sd0)
        begin
            fwd = !y[8];
            if (x > t_pos)
            begin
                zone  = fwd ? jdm_pkg::ZONE_FWD_RIGHT : jdm_pkg::ZONE_BACK_RIGHT;
                left  = hi;
                right = lo;
            end
            else if (x < t_neg)
            begin
                zone  = fwd ? jdm_pkg::ZONE_FWD_LEFT : jdm_pkg::ZONE_BACK_LEFT;
                left  = lo;
                right = hi;
            end
            else
            begin
                zone  = fwd ? jdm_pkg::ZONE_FWD : jdm_pkg::ZONE_BACK;
                left  = hi;
                right = hi;
            end
        end
    end

    // Steer duties to forward or reverse outputs
    always_comb
    begin
        result.right_forward_duty = fwd ? right : 8'd0;
        result.right_reverse_duty = fwd ? 8'd0 : right;
        result.left_forward_duty  = fwd ? left : 8'd0;
        result.left_reverse_duty  = fwd ? 8'd0 : left;
        result.zone               = zone;
    end

endmodule

>>> design/joystick_differential_drive_mixer_top.sv
// Top level: joystick differential drive mixer with input and result registers.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data) carries one raw X/Y sample
//   pair per transfer. Output channel (out_valid / out_stall / out_data) carries
//   the four wheel duties and the zone for that pair, in order.
//   cfg_we / cfg_data write the 8-bit turn threshold; write only while idle.
// Path: a sample accepted into the input register is mapped and mixed, then
//   captured in the result register that drives out_data.
// Throughput: one sample per cycle while out_stall is low. Each axis uses one 20x22
//   reciprocal multiplier between the two registers, which sets the clock limit.
// Reset: rst_n (asynchronous, active low) empties both stages and sets the
//   turn threshold to 60.
// Stall: while out_stall holds a waiting result, the input register still
//   takes one more sample; in_stall rises only once both stages are full,
//   and the waiting result stays unchanged.
module joystick_differential_drive_mixer_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  jdm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output jdm_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    jdm_pkg::in_t   s1_data_reg;
    logic           s2_valid_reg;
    logic           s2_valid_next;
    jdm_pkg::out_t  s2_data_reg;
    logic [7:0]     threshold_reg;
    logic           s2_load;
    logic           s1_load;
    jdm_pkg::axis_t x;
    jdm_pkg::axis_t y;
    jdm_pkg::out_t  mixed;

    // Pipeline advance
    always_comb
    begin
        s2_load       = !s2_valid_reg || !out_stall;
        s1_load       = !s1_valid_reg || s2_load;
        in_stall      = !s1_load;
        s1_valid_next = s1_load ? in_valid : s1_valid_reg;
        s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            threshold_reg <= jdm_pkg::THRESHOLD_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (cfg_we)
                threshold_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
            s1_data_reg <= in_data;
        if (s2_load && s1_valid_reg)
            s2_data_reg <= mixed;
    end

    jdm_axis_map u_axis_map
    (
        .sample (s1_data_reg),
        .x      (x),
        .y      (y)
    );

    jdm_zone_mix u_zone_mix
    (
        .x              (x),
        .y              (y),
        .turn_threshold (threshold_reg),
        .result         (mixed)
    );

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule
